>>> rtl/core/bfi_pkg.sv
package bfi_pkg;

  // memory and stack geometry
  localparam int ADDR_BITS    = 16;
  localparam int MEM_DEPTH    = 1 << ADDR_BITS;
  localparam int LEN_BITS     = ADDR_BITS + 1;
  localparam int LOOP_DEPTH   = 1024;
  localparam int STK_IDX_BITS = $clog2(LOOP_DEPTH);
  localparam int LVL_BITS     = $clog2(LOOP_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [LEN_BITS-1:0]     len_t;
  typedef logic [7:0]              byte_t;
  typedef logic [STK_IDX_BITS-1:0] stk_idx_t;
  typedef logic [LVL_BITS-1:0]     lvl_t;
  typedef logic [2:0]              status_t;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // instruction characters
  localparam byte_t OP_PTR_INC = 8'h3E;  // '>'
  localparam byte_t OP_PTR_DEC = 8'h3C;  // '<'
  localparam byte_t OP_INC     = 8'h2B;  // '+'
  localparam byte_t OP_DEC     = 8'h2D;  // '-'
  localparam byte_t OP_OUT     = 8'h2E;  // '.'
  localparam byte_t OP_IN      = 8'h2C;  // ','
  localparam byte_t OP_OPEN    = 8'h5B;  // '['
  localparam byte_t OP_CLOSE   = 8'h5D;  // ']'

  // status codes
  localparam status_t ST_RUNNING   = 3'd0;
  localparam status_t ST_HALT      = 3'd1;
  localparam status_t ST_UNMATCHED = 3'd2;
  localparam status_t ST_OVERFLOW  = 3'd3;
  localparam status_t ST_MEM_FULL  = 3'd4;

  // write port of the unified memory
  typedef struct packed {
    logic  en;
    addr_t addr;
    byte_t data;
  } mem_wr_t;

  // write port of the loop stack
  typedef struct packed {
    logic     en;
    stk_idx_t idx;
    addr_t    data;
  } stk_wr_t;

endpackage

>>> rtl/core/bf_interpreter_core.sv
// channel   ports                                             beat taken when
// input     in_req_type, in_data_byte                         start && !busy
// result    out_valid, out_byte, out_input_used, out_status   out_strobe
//
// a load or step beat passes through a memory read, then execute and write back
// a '[' on a zero cell scans the program forward byte by byte up to its ']',
// and halts when the scan runs off the program end without a match
// the unified memory port pair sets the rate: one instruction per read/write pass
// after reset busy stays high while all 2**ADDR_BITS (65536) memory cells are cleared
// results are held for one cycle only; the receiver cannot stall them
module bf_interpreter_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  bfi_pkg::byte_t   in_data_byte,
  output logic             out_strobe,
  output logic             out_valid,
  output bfi_pkg::byte_t   out_byte,
  output logic             out_input_used,
  output bfi_pkg::status_t out_status
);
  import bfi_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_SCAN} state_t;
  typedef enum logic [1:0] {RS_LOADING, RS_RUNNING, RS_STOPPED} run_t;

  state_t  state_r, state_nxt;
  run_t    run_r, run_nxt, run_eff;
  status_t stop_code_r, stop_code_nxt;
  len_t    pl_r, pl_nxt;
  len_t    ip_r, ip_nxt;
  addr_t   dp_r, dp_nxt, dp_eff;
  lvl_t    lvl_r, lvl_nxt;
  logic    req_r, req_nxt;
  byte_t   byte_r, byte_nxt;
  len_t    scan_j_r, scan_j_nxt;
  len_t    depth_r, depth_nxt;
  addr_t   clr_addr_r, clr_addr_nxt;

  logic    out_strobe_r, out_strobe_nxt;
  logic    out_valid_r, out_valid_nxt;
  byte_t   out_byte_r, out_byte_nxt;
  logic    out_used_r, out_used_nxt;
  status_t out_status_r, out_status_nxt;

  mem_wr_t  mem_wr;
  stk_wr_t  stk_wr;
  addr_t    rd_a_addr, rd_b_addr;
  byte_t    rd_a_data, rd_b_data;
  stk_idx_t stk_rd_idx;
  addr_t    stk_rd_data;

  len_t  ip_inc, scan_inc, next_ip;
  lvl_t  lvl_dec;
  logic  advance, step_done;

  assign ip_inc   = ip_r + len_t'(1);
  assign scan_inc = scan_j_r + len_t'(1);
  assign lvl_dec  = lvl_r - lvl_t'(1);

  // read addresses: opcode / scan byte on port a, data cell on port b
  always_comb begin
    case (state_r)
      S_IDLE:  rd_a_addr = ip_r[ADDR_BITS-1:0];
      S_EXEC:  rd_a_addr = ip_inc[ADDR_BITS-1:0];
      default: rd_a_addr = scan_inc[ADDR_BITS-1:0];
    endcase
  end
  assign rd_b_addr  = (run_r == RS_LOADING) ? pl_r[ADDR_BITS-1:0] : dp_r;
  assign stk_rd_idx = lvl_dec[STK_IDX_BITS-1:0];

  bfi_data_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  bfi_loop_stack u_stack (
    .clk     (clk),
    .wr      (stk_wr),
    .rd_idx  (stk_rd_idx),
    .rd_data (stk_rd_data)
  );

  // sequencer and execute logic
  always_comb begin
    state_nxt      = state_r;
    run_nxt        = run_r;
    run_eff        = run_r;
    stop_code_nxt  = stop_code_r;
    pl_nxt         = pl_r;
    ip_nxt         = ip_r;
    dp_nxt         = dp_r;
    dp_eff         = dp_r;
    lvl_nxt        = lvl_r;
    req_nxt        = req_r;
    byte_nxt       = byte_r;
    scan_j_nxt     = scan_j_r;
    depth_nxt      = depth_r;
    clr_addr_nxt   = clr_addr_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt  = 1'b0;
    out_byte_nxt   = '0;
    out_used_nxt   = 1'b0;
    out_status_nxt = ST_RUNNING;
    mem_wr         = '0;
    stk_wr         = '0;
    advance        = 1'b0;
    step_done      = 1'b0;
    next_ip        = ip_inc;

    case (state_r)
      S_CLEAR: begin
        mem_wr.en    = 1'b1;
        mem_wr.addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + addr_t'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          byte_nxt  = in_data_byte;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        if (req_r == REQ_LOAD) begin
          // program append
          if (run_r == RS_LOADING) begin
            if (pl_r == len_t'(MEM_DEPTH)) begin
              out_status_nxt = ST_MEM_FULL;
            end else begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = pl_r[ADDR_BITS-1:0];
              mem_wr.data = byte_r;
              pl_nxt      = pl_r + len_t'(1);
            end
          end else if (run_r == RS_STOPPED) begin
            out_status_nxt = stop_code_r;
          end
        end else begin
          step_done = 1'b1;
          // first step leaves loading
          if (run_r == RS_LOADING) begin
            dp_eff = pl_r[ADDR_BITS-1:0];
            dp_nxt = dp_eff;
            if (pl_r == '0) begin
              run_eff       = RS_STOPPED;
              run_nxt       = RS_STOPPED;
              stop_code_nxt = ST_HALT;
            end else begin
              run_eff = RS_RUNNING;
              run_nxt = RS_RUNNING;
            end
          end
          if (run_eff == RS_RUNNING) begin
            advance = 1'b1;
            case (rd_a_data)
              OP_PTR_INC: dp_nxt = dp_eff + addr_t'(1);
              OP_PTR_DEC: dp_nxt = dp_eff - addr_t'(1);
              OP_INC: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = dp_eff;
                mem_wr.data = rd_b_data + byte_t'(1);
              end
              OP_DEC: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = dp_eff;
                mem_wr.data = rd_b_data - byte_t'(1);
              end
              OP_OUT: begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = rd_b_data;
              end
              OP_IN: begin
                mem_wr.en    = 1'b1;
                mem_wr.addr  = dp_eff;
                mem_wr.data  = byte_r;
                out_used_nxt = 1'b1;
              end
              OP_OPEN: begin
                if (rd_b_data != '0) begin
                  if (lvl_r == lvl_t'(LOOP_DEPTH)) begin
                    advance       = 1'b0;
                    run_nxt       = RS_STOPPED;
                    stop_code_nxt = ST_OVERFLOW;
                  end else begin
                    stk_wr.en   = 1'b1;
                    stk_wr.idx  = lvl_r[STK_IDX_BITS-1:0];
                    stk_wr.data = ip_r[ADDR_BITS-1:0];
                    lvl_nxt     = lvl_r + lvl_t'(1);
                  end
                end else begin
                  // zero cell: scan forward for the matching close
                  advance        = 1'b0;
                  step_done      = 1'b0;
                  out_strobe_nxt = 1'b0;
                  state_nxt      = S_SCAN;
                  scan_j_nxt     = ip_inc;
                  depth_nxt      = '0;
                end
              end
              OP_CLOSE: begin
                if (lvl_r == '0) begin
                  advance       = 1'b0;
                  run_nxt       = RS_STOPPED;
                  stop_code_nxt = ST_UNMATCHED;
                end else begin
                  lvl_nxt = lvl_dec;
                  if (rd_b_data != '0) begin
                    next_ip = {1'b0, stk_rd_data};
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_SCAN: begin
        if (scan_j_r >= pl_r) begin
          // no match before program end
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          step_done      = 1'b1;
          ip_nxt         = pl_r;
          run_nxt        = RS_STOPPED;
          stop_code_nxt  = ST_HALT;
        end else begin
          scan_j_nxt = scan_inc;
          case (rd_a_data)
            OP_OPEN: depth_nxt = depth_r + len_t'(1);
            OP_CLOSE: begin
              if (depth_r == '0) begin
                state_nxt      = S_IDLE;
                out_strobe_nxt = 1'b1;
                step_done      = 1'b1;
                advance        = 1'b1;
                next_ip        = scan_inc;
              end else begin
                depth_nxt = depth_r - len_t'(1);
              end
            end
            default: ;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // instruction pointer update and program end check
    if (advance) begin
      if (next_ip >= pl_r) begin
        ip_nxt        = pl_r;
        run_nxt       = RS_STOPPED;
        stop_code_nxt = ST_HALT;
      end else begin
        ip_nxt = next_ip;
      end
    end

    if (step_done) begin
      out_status_nxt = (run_nxt == RS_STOPPED) ? stop_code_nxt : ST_RUNNING;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      run_r        <= RS_LOADING;
      stop_code_r  <= ST_RUNNING;
      pl_r         <= '0;
      ip_r         <= '0;
      dp_r         <= '0;
      lvl_r        <= '0;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_r        <= run_nxt;
      stop_code_r  <= stop_code_nxt;
      pl_r         <= pl_nxt;
      ip_r         <= ip_nxt;
      dp_r         <= dp_nxt;
      lvl_r        <= lvl_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    req_r        <= req_nxt;
    byte_r       <= byte_nxt;
    scan_j_r     <= scan_j_nxt;
    depth_r      <= depth_nxt;
    out_valid_r  <= out_valid_nxt;
    out_byte_r   <= out_byte_nxt;
    out_used_r   <= out_used_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_input_used = out_used_r;
  assign out_status     = out_status_r;

endmodule

>>> rtl/core/bfi_data_mem.sv
module bfi_data_mem (
  input  logic            clk,
  input  bfi_pkg::mem_wr_t wr,
  input  bfi_pkg::addr_t  rd_a_addr,
  input  bfi_pkg::addr_t  rd_b_addr,
  output bfi_pkg::byte_t  rd_a_data,
  output bfi_pkg::byte_t  rd_b_data
);
  import bfi_pkg::*;

  byte_t mem_q [MEM_DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_q[wr.addr] <= wr.data;
    end
    rd_a_data <= mem_q[rd_a_addr];
    rd_b_data <= mem_q[rd_b_addr];
  end

endmodule

>>> rtl/core/bfi_loop_stack.sv
module bfi_loop_stack (
  input  logic             clk,
  input  bfi_pkg::stk_wr_t wr,
  input  bfi_pkg::stk_idx_t rd_idx,
  output bfi_pkg::addr_t   rd_data
);
  import bfi_pkg::*;

  addr_t stk_q [LOOP_DEPTH];

  // return addresses of open loops, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      stk_q[wr.idx] <= wr.data;
    end
    rd_data <= stk_q[rd_idx];
  end

endmodule
